// File: hw/rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int KEY_W = 32;

   // action codes
   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_DELETE   = 2'd1;
   localparam logic [1:0] ACT_INCREASE = 2'd2;

   // status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_EMPTY       = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND   = 3'd2;
   localparam logic [2:0] STATUS_NOT_GREATER = 3'd3;
   localparam logic [2:0] STATUS_FULL        = 3'd4;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [KEY_W-1:0] key_value;
      logic signed [KEY_W-1:0] new_key_value;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [KEY_W-1:0] min_key;
      logic                    is_empty;
      logic [4:0]              entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type             op;
      logic signed [KEY_W-1:0] key;
   } cell_cmd_type;

   // compare results a cell reports against the broadcast key
   typedef struct packed {
      logic gt;
      logic eq;
   } cell_flags_type;

endpackage

// File: hw/rtl/spq_cell.sv
// One compare-and-shift cell of the sorted key chain.
module spq_cell
   import spq_pkg::*;
(
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic                    occupied,
   input  logic                    at_end,
   input  logic signed [KEY_W-1:0] left_key,
   input  logic                    left_gt,
   input  logic signed [KEY_W-1:0] right_key,
   output logic signed [KEY_W-1:0] key,
   output cell_flags_type          flags
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;
   logic                    gt;
   logic                    eq;

   assign gt    = occupied && (key_ff > cmd.key);
   assign eq    = occupied && (key_ff == cmd.key);
   assign key   = key_ff;
   assign flags = '{gt: gt, eq: eq};

   always_comb begin
      key_in = key_ff;
      case (cmd.op)
         CELL_INSERT: begin
            // shift right behind the new key, or take it at its slot
            if (gt || at_end) begin
               key_in = left_gt ? left_key : cmd.key;
            end
         end
         CELL_REMOVE: begin
            // close the gap from the right
            if (gt || eq) begin
               key_in = right_key;
            end
         end
         default: key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// An action runs in EXEC (then REINSERT for a successful increase-key), and its reply is
// loaded in DONE from the updated chain once the output register is free. A new action
// is taken only from IDLE or DONE, so the block finishes one action before the next.
// Reset clears the count, the control state and the result valid; cell keys are not
// cleared and are only read below the count.
// Top level of the sorted min priority queue built from a chain of cells.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_EXEC     = 4'b0010,
      ST_REINSERT = 4'b0100,
      ST_DONE     = 4'b1000
   } fsm_state_type;

   fsm_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   req_type       req_ff, req_in;
   logic [2:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_cmd_type            cell_cmd;
   logic signed [KEY_W-1:0] cell_key   [DEPTH];
   cell_flags_type          cell_flags [DEPTH];
   logic [DEPTH-1:0]        eq_vec;
   logic [DEPTH-1:0]        gt_vec;

   logic          found;
   logic          full;
   logic          empty;
   logic          slot_free;
   logic [CW+4:0] count_ext;

   // Chain of cells: each sees its neighbors' keys and the broadcast command.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic                    left_gt;
      logic signed [KEY_W-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_key = KEY_MIN;
         assign left_gt  = 1'b0;
      end else begin : g_inner
         assign left_key = cell_key[i-1];
         assign left_gt  = gt_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_body
         assign right_key = cell_key[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .occupied  (count_ff > CW'(i)),
         .at_end    (count_ff == CW'(i)),
         .left_key  (left_key),
         .left_gt   (left_gt),
         .right_key (right_key),
         .key       (cell_key[i]),
         .flags     (cell_flags[i])
      );

      assign eq_vec[i] = cell_flags[i].eq;
      assign gt_vec[i] = cell_flags[i].gt;
   end

   assign found     = |eq_vec;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign count_ext = {5'b0, count_ff};

   // Accept from idle, or straight out of the reply cycle when the output slot frees.
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && slot_free);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // The broadcast key depends only on state and action, never on the compare flags.
      cell_cmd.op = CELL_HOLD;
      if (state_ff == ST_REINSERT) begin
         cell_cmd.key = req_ff.new_key_value;
      end else if (req_ff.action == ACT_DELETE) begin
         // every stored key is at least the minimum, so the whole chain moves left
         cell_cmd.key = KEY_MIN;
      end else begin
         cell_cmd.key = req_ff.key_value;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            state_in  = ST_DONE;
            case (req_ff.action)
               ACT_INSERT: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cell_cmd.op = CELL_INSERT;
                     count_in    = count_ff + CW'(1);
                  end
               end
               ACT_DELETE: begin
                  if (empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cell_cmd.op = CELL_REMOVE;
                     count_in    = count_ff - CW'(1);
                  end
               end
               ACT_INCREASE: begin
                  if (empty) begin
                     status_in = STATUS_EMPTY;
                  end else if (!found) begin
                     status_in = STATUS_NOT_FOUND;
                  end else if (!(req_ff.new_key_value > req_ff.key_value)) begin
                     status_in = STATUS_NOT_GREATER;
                  end else begin
                     // drop the first match now, place the new key next cycle
                     cell_cmd.op = CELL_REMOVE;
                     count_in    = count_ff - CW'(1);
                     state_in    = ST_REINSERT;
                  end
               end
               default: status_in = STATUS_OK;
            endcase
         end
         ST_REINSERT: begin
            cell_cmd.op = CELL_INSERT;
            count_in    = count_ff + CW'(1);
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hold here until the output register is free, then load the reply
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.min_key     = empty ? '0 : cell_key[0];
               rsp_in.is_empty    = empty;
               rsp_in.entry_count = count_ext[4:0];
               if (req_valid) begin
                  req_in   = req_payload;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Stored keys must stay in ascending order across the occupied cells.
   logic [DEPTH-2:0] order_ok;
   always_comb begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         order_ok[i] = (count_ff <= CW'(i + 1)) || (cell_key[i] <= cell_key[i+1]);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("stored count exceeds depth");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("cell chain out of order");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cell_cmd.op == CELL_INSERT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance count");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cell_cmd.op == CELL_REMOVE |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not drop count");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC)
      else $error("accepted transfer not executed");

endmodule

// File: bench/sorted_priority_queue_test.sv
// Self-checking bench for the sorted min priority queue, with a queue-based predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int RANDOM_ACTIONS = 1300;
   localparam int BACKLOG_CYCLES = 400;

   // Action code 3 is not decoded by the block; it must come back as a plain OK.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef logic signed [KEY_W-1:0] key_word_type;
   typedef key_word_type key_list_type[$];

   localparam key_word_type KEY_MAX_VALUE = 32'sh7FFF_FFFF;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Keys the block should hold, advanced on each accepted transfer.
   key_list_type tracked_keys;
   // Keys as the stimulus generator expects them, used only to aim increase-key at
   // keys that are really stored.
   key_list_type planned_keys;

   req_type     pending_actions[$];
   rsp_type     awaited_replies[$];
   int unsigned actions_accepted = 0;
   int unsigned total_actions    = 0;
   int unsigned error_count      = 0;

   int unsigned send_gap        = 0;
   int unsigned drain_gap       = 0;
   int unsigned results_drained = 0;
   int unsigned backlog_hold    = 0;
   int unsigned next_backlog_at = 150;

   sorted_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Place a key after every key equal to it, keeping ascending order.
   function automatic void place_sorted(ref key_list_type keys,
                                        input key_word_type new_entry);
      int pos;
      pos = keys.size();
      while (pos > 0 && keys[pos-1] > new_entry) pos--;
      keys.insert(pos, new_entry);
   endfunction

   // Apply one action to a key list and return the reply the block owes for it.
   function automatic rsp_type apply_action(ref key_list_type keys, input req_type item);
      rsp_type      reply;
      key_word_type old_key;
      key_word_type new_key;
      int           hit;
      old_key      = item.key_value;
      new_key      = item.new_key_value;
      reply.status = STATUS_OK;
      case (item.action)
         ACT_INSERT: begin
            if (keys.size() >= QUEUE_DEPTH) reply.status = STATUS_FULL;
            else place_sorted(keys, old_key);
         end
         ACT_DELETE: begin
            if (keys.size() == 0) reply.status = STATUS_EMPTY;
            else void'(keys.pop_front());
         end
         ACT_INCREASE: begin
            if (keys.size() == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               // search first, then the ordering test on the two keys
               hit = -1;
               foreach (keys[i]) if (hit < 0 && keys[i] == old_key) hit = i;
               if (hit < 0) begin
                  reply.status = STATUS_NOT_FOUND;
               end else if (!(new_key > old_key)) begin
                  reply.status = STATUS_NOT_GREATER;
               end else begin
                  // removal frees a slot, so this works on a full store too
                  keys.delete(hit);
                  place_sorted(keys, new_key);
               end
            end
         end
         default: ;
      endcase
      reply.min_key     = (keys.size() != 0) ? keys[0] : key_word_type'(0);
      reply.is_empty    = (keys.size() == 0);
      reply.entry_count = 5'(keys.size());
      return reply;
   endfunction

   // Idle length for either side: mostly none or short, now and then long, and
   // whole stretches with no idling at all.
   function automatic int unsigned pick_gap(int unsigned seq);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if ((seq / 128) % 4 == 1) return 0;
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Keys biased toward a narrow band for duplicates, plus the extremes.
   function automatic key_word_type random_key();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return key_word_type'($urandom_range(0, 16)) - 8;
      if (roll == 5) begin
         case ($urandom_range(0, 3))
            0:       return KEY_MIN;
            1:       return KEY_MAX_VALUE;
            2:       return key_word_type'(0);
            default: return key_word_type'(-1);
         endcase
      end
      return key_word_type'($urandom);
   endfunction

   task automatic queue_action(input logic [1:0] action, input key_word_type old_key,
                               input key_word_type new_key);
      req_type item;
      item.action        = action;
      item.key_value     = old_key;
      item.new_key_value = new_key;
      void'(apply_action(planned_keys, item));
      pending_actions.push_back(item);
   endtask

   // Sender: present queued actions, hold each until its transfer, then maybe idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_replies.push_back(apply_action(tracked_keys, req_payload));
            actions_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_actions.size() > 0) begin
               req_payload <= pending_actions.pop_front();
               req_valid   <= 1'b1;
               send_gap = pick_gap(actions_accepted);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random short and long stalls, plus a few long backlogs that fill the
   // block and push back on the sender while it keeps offering actions.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         drain_gap    = 0;
         backlog_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) results_drained++;
         if (backlog_hold > 0) begin
            backlog_hold--;
            rsp_ready <= 1'b0;
         end else if (results_drained >= next_backlog_at) begin
            backlog_hold = BACKLOG_CYCLES;
            next_backlog_at += 500;
            rsp_ready <= 1'b0;
         end else if (drain_gap > 0) begin
            drain_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready) drain_gap = pick_gap(results_drained);
         end
      end
   end

   // Monitor: match each reply transfer against the oldest awaited reply.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_replies.size() == 0) begin
            $error("reply with nothing awaited: %p", rsp_payload);
            error_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.min_key !== want.min_key) begin
               $error("min_key: expected %0d, got %0d", want.min_key, rsp_payload.min_key);
               error_count++;
            end
            if (rsp_payload.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_payload.is_empty);
               error_count++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_payload.entry_count);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned  mode_left;
      int unsigned  fill_bias;
      int unsigned  insert_pct;
      int unsigned  roll;
      key_word_type old_key;
      key_word_type new_key;
      longint       headroom;

      // Directed: empty-store errors, extremes, duplicates, every increase outcome.
      queue_action(ACT_DELETE, random_key(), random_key());
      queue_action(ACT_INCREASE, 32'sd1, 32'sd2);
      queue_action(ACT_INSERT, KEY_MIN, random_key());
      queue_action(ACT_INSERT, KEY_MAX_VALUE, random_key());
      queue_action(ACT_INSERT, 32'sd0, random_key());
      queue_action(ACT_INSERT, -32'sd1, random_key());
      queue_action(ACT_INSERT, 32'sd0, random_key());
      // first of the two zeros moves, the other stays
      queue_action(ACT_INCREASE, 32'sd0, 32'sd5);
      queue_action(ACT_INCREASE, 32'sd5, 32'sd5);
      queue_action(ACT_INCREASE, 32'sd7, 32'sd9);
      queue_action(ACT_INCREASE, KEY_MAX_VALUE, KEY_MIN);
      // the minimum jumps to the far end
      queue_action(ACT_INCREASE, KEY_MIN, KEY_MAX_VALUE);
      queue_action(ACT_UNUSED, random_key(), random_key());
      // fill to capacity, refuse one more, then increase on the full store
      for (int i = 0; i < 11; i++) queue_action(ACT_INSERT, random_key(), random_key());
      queue_action(ACT_INSERT, 32'sd3, random_key());
      queue_action(ACT_INCREASE, 32'sd0, 32'sd100);

      // Random: stretches that lean toward filling, draining or neither, so the
      // store keeps passing through full and empty.
      mode_left = 0;
      fill_bias = 0;
      for (int n = 0; n < RANDOM_ACTIONS; n++) begin
         if (mode_left == 0) begin
            fill_bias = $urandom_range(0, 2);
            mode_left = $urandom_range(30, 120);
         end
         mode_left--;
         insert_pct = (fill_bias == 0) ? 60 : (fill_bias == 1) ? 15 : 37;
         roll       = $urandom_range(0, 99);
         if (roll < insert_pct) begin
            queue_action(ACT_INSERT, random_key(), key_word_type'($urandom));
         end else if (roll < 75) begin
            queue_action(ACT_DELETE, key_word_type'($urandom), key_word_type'($urandom));
         end else if (roll < 98) begin
            if (planned_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
               old_key  = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
               headroom = longint'(KEY_MAX_VALUE) - longint'(old_key);
               if (headroom == 0 || $urandom_range(0, 3) == 0)
                  new_key = random_key();
               else if ($urandom_range(0, 1) == 1)
                  new_key = key_word_type'(longint'(old_key) + 1 +
                                           longint'($urandom_range(0, 19)) % headroom);
               else
                  new_key = key_word_type'(longint'(old_key) + 1 +
                                           longint'({$urandom, $urandom} % headroom));
            end else begin
               old_key = random_key();
               new_key = random_key();
            end
            queue_action(ACT_INCREASE, old_key, new_key);
         end else begin
            queue_action(ACT_UNUSED, key_word_type'($urandom), key_word_type'($urandom));
         end
      end
      total_actions = pending_actions.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (actions_accepted < total_actions) @(posedge clock);
      while (awaited_replies.size() > 0) @(posedge clock);
      // then wait on to catch any stray reply
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
